// ===== hdl/mnsv_pkg.sv =====
// shared constants and types of the note stack voice unit
`default_nettype none

package mnsv_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int BYTE_W = 8;
  localparam int NOTE_W = 7;
  localparam int AMP_W  = 8;
  localparam int HELD_W = 5;
  localparam int STAT_W = 4;

  localparam logic [AMP_W-1:0]  AMP_ON          = 8'hFF;
  localparam logic [AMP_W-1:0]  AMP_OFF         = 8'h00;
  localparam logic [STAT_W-1:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [STAT_W-1:0] STATUS_NOTE_ON  = 4'h9;

  typedef enum logic [1:0] {
    OP_REPORT,
    OP_PRESS,
    OP_RELEASE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NOTE_W-1:0] note;
  } cmd_t;

  // handshake between command queue and back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [AMP_W-1:0]  amp;
    logic [HELD_W-1:0] held;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/mnsv_front.sv =====
// midi byte parser: running status, data phase, command classification
`default_nettype none

module mnsv_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [mnsv_pkg::BYTE_W-1:0] midi_byte,
  output mnsv_pkg::cmd_t                   cmd,
  output logic                             cmd_push
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NOTE = 2'd1;
  localparam logic [1:0] PH_VEL  = 2'd2;

  logic [1:0]                        phase;
  logic [1:0]                        phase_next;
  logic [mnsv_pkg::STAT_W-1:0]       status;
  logic [mnsv_pkg::STAT_W-1:0]       status_next;
  logic [mnsv_pkg::NOTE_W-1:0]       note_latch;
  logic [mnsv_pkg::NOTE_W-1:0]       data;

  assign data = midi_byte[mnsv_pkg::NOTE_W-1:0];

  always_comb begin
    phase_next  = phase;
    status_next = status;
    cmd_push    = 1'b0;
    if (accept) begin
      if (midi_byte[mnsv_pkg::BYTE_W-1]) begin
        status_next = midi_byte[mnsv_pkg::BYTE_W-1 -: mnsv_pkg::STAT_W];
        phase_next  = PH_NOTE;
      end else begin
        case (phase)
          PH_NOTE: phase_next = PH_VEL;
          PH_VEL: begin
            phase_next = PH_NOTE;
            cmd_push   = 1'b1;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // note-on with zero velocity counts as a release
  always_comb begin
    cmd.note = note_latch;
    if (status == mnsv_pkg::STATUS_NOTE_ON && data != '0) begin
      cmd.op = mnsv_pkg::OP_PRESS;
    end else if (status inside {mnsv_pkg::STATUS_NOTE_OFF, mnsv_pkg::STATUS_NOTE_ON}) begin
      cmd.op = mnsv_pkg::OP_RELEASE;
    end else begin
      cmd.op = mnsv_pkg::OP_REPORT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      status <= mnsv_pkg::STATUS_NOTE_OFF;
    end else begin
      phase  <= phase_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !midi_byte[mnsv_pkg::BYTE_W-1] && phase == PH_NOTE) begin
      note_latch <= data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mnsv_cmd_fifo.sv =====
// two-entry command queue between parser and stack engine
`default_nettype none

module mnsv_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mnsv_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output mnsv_pkg::cmd_head_t head
);

  mnsv_pkg::cmd_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign full       = (fill == 2'd2);
  assign head.valid = (fill != 2'd0);
  assign head.cmd   = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mnsv_back.sv =====
// stack engine: push, compacting release scan, result register
`default_nettype none

module mnsv_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mnsv_pkg::cmd_head_t        head,
  output logic                            cmd_pop,
  input  wire logic                       res_pop,
  output logic                            res_valid,
  output mnsv_pkg::result_t               res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TOP  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [mnsv_pkg::CNT_W-1:0] CNT_ONE  = mnsv_pkg::CNT_W'(1);
  localparam logic [mnsv_pkg::CNT_W-1:0] CNT_FULL = mnsv_pkg::CNT_W'(mnsv_pkg::STACK_DEPTH);

  logic [1:0]                      state;
  logic [mnsv_pkg::NOTE_W-1:0]     held [mnsv_pkg::STACK_DEPTH];
  logic [mnsv_pkg::CNT_W-1:0]      count;
  logic [mnsv_pkg::NOTE_W-1:0]     highest;
  logic [mnsv_pkg::NOTE_W-1:0]     sounding;
  logic [mnsv_pkg::AMP_W-1:0]      amp;
  logic [mnsv_pkg::NOTE_W-1:0]     key;
  logic [mnsv_pkg::IDX_W-1:0]      rd;
  logic [mnsv_pkg::CNT_W-1:0]      wr;
  logic                            hit;

  logic [mnsv_pkg::CNT_W-1:0]      count_m1;
  logic [mnsv_pkg::IDX_W-1:0]      rd_addr;
  logic [mnsv_pkg::NOTE_W-1:0]     rd_data;
  logic                            match;
  logic                            hit_next;
  logic [mnsv_pkg::CNT_W-1:0]      wr_next;
  logic                            scan_last;
  logic                            res_free;

  assign count_m1  = count - CNT_ONE;
  assign rd_addr   = (state == ST_TOP) ? count_m1[mnsv_pkg::IDX_W-1:0] : rd;
  assign rd_data   = held[rd_addr];
  assign match     = (rd_data == key);
  assign hit_next  = hit || match;
  assign wr_next   = match ? wr : wr + CNT_ONE;
  assign scan_last = (rd == count_m1[mnsv_pkg::IDX_W-1:0]);
  assign res_free  = !res_valid || res_pop;
  assign cmd_pop   = (state == ST_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      highest   <= '0;
      sounding  <= '0;
      amp       <= mnsv_pkg::AMP_OFF;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            case (head.cmd.op)
              mnsv_pkg::OP_PRESS: begin
                amp <= mnsv_pkg::AMP_ON;
                if (count < CNT_FULL) begin
                  count <= count + CNT_ONE;
                end
                if (head.cmd.note > highest) begin
                  highest  <= head.cmd.note;
                  sounding <= head.cmd.note;
                end
                state <= ST_DONE;
              end
              mnsv_pkg::OP_RELEASE: begin
                if (count == '0) begin
                  sounding <= '0;
                  amp      <= mnsv_pkg::AMP_OFF;
                  state    <= ST_DONE;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            if (!hit_next) begin
              state <= ST_DONE;
            end else begin
              count <= wr_next;
              if (wr_next == '0) begin
                sounding <= '0;
                amp      <= mnsv_pkg::AMP_OFF;
                state    <= ST_DONE;
              end else begin
                state <= ST_TOP;
              end
            end
          end
        end
        ST_TOP: begin
          sounding <= rd_data;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scan pointers, stack entries and result word
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        key <= head.cmd.note;
        rd  <= '0;
        wr  <= '0;
        hit <= 1'b0;
        if (head.valid && head.cmd.op == mnsv_pkg::OP_PRESS && count < CNT_FULL) begin
          held[count[mnsv_pkg::IDX_W-1:0]] <= head.cmd.note;
        end
      end
      ST_SCAN: begin
        hit <= hit_next;
        wr  <= wr_next;
        rd  <= rd + mnsv_pkg::IDX_W'(1);
        if (!match) begin
          held[wr[mnsv_pkg::IDX_W-1:0]] <= rd_data;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          res.note <= sounding;
          res.amp  <= amp;
          res.held <= mnsv_pkg::HELD_W'(count);
        end
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("stack count beyond depth");

  a_silent_iff_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (amp == mnsv_pkg::AMP_OFF))
    else $error("amplitude disagrees with stack fill");

  a_silent_note: assert property (@(posedge clk) disable iff (rst)
    (amp == mnsv_pkg::AMP_OFF) |-> (sounding == '0))
    else $error("note sounding while amplitude is off");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (count != '0 && wr <= mnsv_pkg::CNT_W'(rd)))
    else $error("scan running on empty stack or write ahead of read");

endmodule

`default_nettype wire

// ===== hdl/midi_note_stack_voice_unit.sv =====
// monophonic midi voice with a note priority stack, top level
//
// input: one midi byte per word; a word is taken on a clock edge with push
// high and full low. status bytes set running status, two data bytes make a
// message. each completed message yields one result word; status bytes and
// stray data bytes yield none.
// output: note_out, amplitude_out and held_count show the oldest result while
// empty is low; it is taken on an edge with pop high.
// sequence: a press, a non-note message or a release on an empty stack goes
// from the idle state straight to the done state; any other release scans
// the stack one entry a cycle, then, if it dropped the note and notes remain,
// reads the new top note; the done state registers the result word.
// throughput: a byte a cycle while full is low; presses hold input up only
// while pop is low. a two-word command queue sits between the parser and the
// stack engine, so bytes keep flowing while a release scan runs; full rises
// once two messages are waiting. the result register holds while pop stays
// low, and the engine then waits with the next result until it is taken.
// reset (rst, synchronous): running status note-off, stack empty, silent,
// highest note 0, both queues empty.
`default_nettype none

module midi_note_stack_voice_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [mnsv_pkg::BYTE_W-1:0] midi_byte,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [mnsv_pkg::NOTE_W-1:0]      note_out,
  output logic [mnsv_pkg::AMP_W-1:0]       amplitude_out,
  output logic [mnsv_pkg::HELD_W-1:0]      held_count
);

  mnsv_pkg::cmd_t      front_cmd;
  logic                front_push;
  mnsv_pkg::cmd_head_t head;
  logic                cmd_pop;
  logic                res_valid;
  mnsv_pkg::result_t   res;
  logic                accept;

  assign accept = push && !full;

  mnsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .midi_byte (midi_byte),
    .cmd       (front_cmd),
    .cmd_push  (front_push)
  );

  mnsv_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_cmd (front_cmd),
    .full     (full),
    .pop      (cmd_pop),
    .head     (head)
  );

  mnsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .cmd_pop   (cmd_pop),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign empty         = !res_valid;
  assign note_out      = res.note;
  assign amplitude_out = res.amp;
  assign held_count    = res.held;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench of the note stack voice unit: midi byte stream in, predicted voice words checked
module testbench;

  localparam int ITEM_TARGET = 450;
  localparam int LIMIT       = 400000;
  localparam int TAIL_CYCLES = 40;

  localparam logic [mnsv_pkg::STAT_W-1:0] STATUS_CTRL = 4'hB;
  localparam logic [mnsv_pkg::STAT_W-1:0] STATUS_SYS  = 4'hF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NOTE,
    PH_VELOCITY
  } phase_t;

  class voice_tracker;
    logic [mnsv_pkg::STAT_W-1:0] cur_status;
    phase_t                      msg_phase;
    logic [mnsv_pkg::NOTE_W-1:0] note_hold;
    logic [mnsv_pkg::NOTE_W-1:0] held_notes [mnsv_pkg::STACK_DEPTH];
    int unsigned                 depth_used;
    logic [mnsv_pkg::NOTE_W-1:0] top_seen;
    logic [mnsv_pkg::NOTE_W-1:0] voice_note;
    logic [mnsv_pkg::AMP_W-1:0]  voice_amp;
    mnsv_pkg::result_t           due_words [$];
    int                          errors;

    function new();
      cur_status = mnsv_pkg::STATUS_NOTE_OFF;
      msg_phase  = PH_IDLE;
      note_hold  = '0;
      foreach (held_notes[i]) held_notes[i] = '0;
      depth_used = 0;
      top_seen   = '0;
      voice_note = '0;
      voice_amp  = mnsv_pkg::AMP_OFF;
      errors     = 0;
    endfunction

    function void press_key();
      voice_amp = mnsv_pkg::AMP_ON;
      if (depth_used < mnsv_pkg::STACK_DEPTH) begin
        held_notes[depth_used] = note_hold;
        depth_used++;
      end
      if (note_hold > top_seen) begin
        top_seen   = note_hold;
        voice_note = note_hold;
      end
    endfunction

    function void release_key();
      int unsigned wr;
      bit hit;
      wr  = 0;
      hit = 0;
      if (depth_used == 0) begin
        voice_note = '0;
        voice_amp  = mnsv_pkg::AMP_OFF;
        return;
      end
      // compact the stack, dropping every copy of the note
      for (int rd = 0; rd < depth_used; rd++) begin
        if (held_notes[rd] == note_hold) begin
          hit = 1;
        end else begin
          held_notes[wr] = held_notes[rd];
          wr++;
        end
      end
      if (!hit) return;
      depth_used = wr;
      for (int i = wr; i < mnsv_pkg::STACK_DEPTH; i++) held_notes[i] = '0;
      if (depth_used > 0) begin
        voice_note = held_notes[depth_used - 1];
      end else begin
        voice_note = '0;
        voice_amp  = mnsv_pkg::AMP_OFF;
      end
    endfunction

    function void take_byte(logic [mnsv_pkg::BYTE_W-1:0] b);
      mnsv_pkg::result_t word;
      if (b[7]) begin
        cur_status = b[7:4];
        msg_phase  = PH_NOTE;
        return;
      end
      if (msg_phase == PH_NOTE) begin
        note_hold = b[6:0];
        msg_phase = PH_VELOCITY;
        return;
      end
      if (msg_phase != PH_VELOCITY) return;
      msg_phase = PH_NOTE;
      if (cur_status == mnsv_pkg::STATUS_NOTE_OFF) begin
        release_key();
      end else if (cur_status == mnsv_pkg::STATUS_NOTE_ON) begin
        if (b[6:0] == 0) release_key();
        else press_key();
      end
      word.note = voice_note;
      word.amp  = voice_amp;
      word.held = mnsv_pkg::HELD_W'(depth_used);
      due_words.push_back(word);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_word(logic [mnsv_pkg::NOTE_W-1:0] note, logic [mnsv_pkg::AMP_W-1:0] amp,
                    logic [mnsv_pkg::HELD_W-1:0] held);
      mnsv_pkg::result_t want;
      if (due_words.size() == 0) begin
        report($sformatf("word note %0d amp %0d held %0d with nothing due", note, amp, held));
        return;
      end
      want = due_words.pop_front();
      if (note !== want.note)
        report($sformatf("note_out %0d, want %0d", note, want.note));
      if (amp !== want.amp)
        report($sformatf("amplitude_out %0d, want %0d", amp, want.amp));
      if (held !== want.held)
        report($sformatf("held_count %0d, want %0d", held, want.held));
    endtask
  endclass

  logic                        clk;
  logic                        rst;
  logic                        push;
  logic                        full;
  logic [mnsv_pkg::BYTE_W-1:0] midi_byte;
  logic                        empty;
  logic                        pop;
  logic [mnsv_pkg::NOTE_W-1:0] note_out;
  logic [mnsv_pkg::AMP_W-1:0]  amplitude_out;
  logic [mnsv_pkg::HELD_W-1:0] held_count;

  midi_note_stack_voice_unit dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .midi_byte     (midi_byte),
    .empty         (empty),
    .pop           (pop),
    .note_out      (note_out),
    .amplitude_out (amplitude_out),
    .held_count    (held_count)
  );

  voice_tracker tracker = new();
  bit           idle_on = 1;
  int           sent = 0;
  int unsigned  cycles = 0;
  int           pool_base = 40;
  int           press_bias = 65;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) tracker.check_word(note_out, amplitude_out, held_count);
  end

  // result side: pop high except for random stall bursts
  initial begin
    int stall;
    stall = 0;
    pop   = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pop <= 0;
        stall--;
      end else begin
        pop <= 1;
        if (idle_on && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 10);
      end
    end
  end

  task automatic send_byte(logic [mnsv_pkg::BYTE_W-1:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        push <= 0;
      end
    end
    @(negedge clk);
    push      <= 1;
    midi_byte <= b;
    do @(posedge clk); while (full);
    tracker.take_byte(b);
    sent++;
  endtask

  // drop push first so the last word is not taken twice
  task automatic wait_drained();
    @(negedge clk);
    push <= 0;
    while (tracker.due_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [mnsv_pkg::NOTE_W-1:0] pool_note();
    if ($urandom_range(0, 9) == 0) return mnsv_pkg::NOTE_W'($urandom_range(0, 127));
    return mnsv_pkg::NOTE_W'(pool_base + $urandom_range(0, 7));
  endfunction

  task automatic random_message();
    int kind;
    int pick;
    logic [mnsv_pkg::STAT_W-1:0] stat;
    logic [6:0] vel;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) pool_base = $urandom_range(0, 120);
    if ($urandom_range(0, 99) < 5) press_bias = $urandom_range(40, 85);
    if (kind < 4) begin
      // long run of presses, enough to overflow the stack
      send_byte({mnsv_pkg::STATUS_NOTE_ON, 4'($urandom_range(0, 15))});
      repeat (18) begin
        send_byte({1'b0, pool_note()});
        send_byte({1'b0, 7'($urandom_range(1, 127))});
      end
    end else if (kind < 14) begin
      send_byte(mnsv_pkg::BYTE_W'($urandom_range(0, 255)));
    end else if (kind < 20) begin
      // message cut short by the next status
      send_byte(mnsv_pkg::BYTE_W'($urandom_range(128, 255)));
      send_byte({1'b0, pool_note()});
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        stat = 4'($urandom_range(10, 15));
        vel  = 7'($urandom_range(0, 127));
      end else if (pick < press_bias) begin
        stat = mnsv_pkg::STATUS_NOTE_ON;
        vel  = 7'($urandom_range(1, 127));
      end else if ($urandom_range(0, 1) == 0) begin
        stat = mnsv_pkg::STATUS_NOTE_ON;
        vel  = '0;
      end else begin
        stat = mnsv_pkg::STATUS_NOTE_OFF;
        vel  = 7'($urandom_range(0, 127));
      end
      if (tracker.msg_phase != PH_NOTE || tracker.cur_status != stat ||
          $urandom_range(0, 3) == 0)
        send_byte({stat, 4'($urandom_range(0, 15))});
      send_byte({1'b0, pool_note()});
      send_byte({1'b0, vel});
    end
  endtask

  initial begin
    bit drained_mid;
    drained_mid = 0;
    rst       = 1;
    push      = 0;
    midi_byte = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // data with no status yet is dropped
    send_byte(8'h45);
    send_byte(8'h00);
    // press, then presses below the highest note, running status
    send_byte({mnsv_pkg::STATUS_NOTE_ON, 4'h0});
    send_byte(8'd60);  send_byte(8'd100);
    send_byte(8'd50);  send_byte(8'd1);
    send_byte(8'd0);   send_byte(8'd127);
    // note-off of a note not held
    send_byte({mnsv_pkg::STATUS_NOTE_OFF, 4'hF});
    send_byte(8'd127); send_byte(8'd0);
    // note-off leaving notes held
    send_byte(8'd50);  send_byte(8'd64);
    // note-on with zero velocity releases
    send_byte({mnsv_pkg::STATUS_NOTE_ON, 4'hF});
    send_byte(8'd0);   send_byte(8'd0);
    // half message restarted by a controller status
    send_byte({mnsv_pkg::STATUS_NOTE_ON, 4'h0});
    send_byte(8'd70);
    send_byte({STATUS_CTRL, 4'h3});
    send_byte(8'd7);   send_byte(8'd100);
    send_byte({STATUS_SYS, 4'hF});
    send_byte(8'd1);   send_byte(8'd2);
    // release the last note, then release on an empty stack
    send_byte({mnsv_pkg::STATUS_NOTE_OFF, 4'h0});
    send_byte(8'd60);  send_byte(8'd64);
    send_byte(8'd60);  send_byte(8'd64);
    wait_drained();

    while (sent < ITEM_TARGET) begin
      idle_on = !((sent >= 200 && sent < 260) || sent >= ITEM_TARGET - 80);
      if (!drained_mid && sent >= 300) begin
        wait_drained();
        drained_mid = 1;
      end
      random_message();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    while (tracker.due_words.size() != 0) begin
      void'(tracker.due_words.pop_front());
      tracker.report("expected word never arrived");
    end
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
